/* hdl/slot_table_first_fit_allocator_top_macros.svh */
// Assertion macros for the slot table allocator.
// Included by stfa_scan, which checks its own control logic.
`ifndef SLOT_TABLE_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define SLOT_TABLE_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define STFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stfa_pkg.sv */
// Shared types and constants of the slot table allocator.
// No dependencies.
package stfa_pkg;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned ADDR_SPACE = 65536;

    localparam logic [SIZE_W-1:0] MAX_SIZE = 17'd65536;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } t_slot;

endpackage

/* hdl/stfa_if.sv */
// Request and response channel interfaces of the slot table allocator.
// Depends on stfa_pkg.
interface stfa_req_if import stfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output operation, output request_size,
                    output free_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input free_address, output ready);
endinterface

interface stfa_rsp_if import stfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    t_status           status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

/* hdl/stfa_slot_mem.sv */
// Slot start/end storage: two synchronous memories, one read port each.
// Depends on stfa_pkg.
module stfa_slot_mem import stfa_pkg::*; #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_rd_start_addr,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_rd_end_addr,
    output t_slot                         o_rd,
    input  logic                          i_wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_wr_addr,
    input  t_slot                         i_wr
);

    logic [ADDR_W-1:0] mem_start [SLOT_COUNT];
    logic [ADDR_W-1:0] mem_end   [SLOT_COUNT];
    logic [ADDR_W-1:0] r_start_q;
    logic [ADDR_W-1:0] r_end_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_start[i_wr_addr] <= i_wr.start_addr;
            mem_end[i_wr_addr]   <= i_wr.end_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_q <= mem_start[i_rd_start_addr];
        r_end_q   <= mem_end[i_rd_end_addr];
    end

    assign o_rd.start_addr = r_start_q;
    assign o_rd.end_addr   = r_end_q;

endmodule

/* hdl/stfa_scan.sv */
// Request sequencer: slot scan, fit test, used bits and slot write-back.
// Depends on stfa_pkg, stfa_slot_mem and the assertion macro header.
`include "slot_table_first_fit_allocator_top_macros.svh"

module stfa_scan import stfa_pkg::*; #(
    parameter int SLOT_COUNT   = 64,
    parameter int MEMORY_BYTES = 65536,
    parameter int HEAP_OFFSET  = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_rsp o_res
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = IW + 1;
    localparam int unsigned HEAP_LIMIT =
        (MEMORY_BYTES > ADDR_SPACE) ? ADDR_SPACE : MEMORY_BYTES;
    localparam logic [18:0] LIMIT_W = 19'(HEAP_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_faddr;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [IW-1:0]       r_ev_idx, n_ev_idx;
    logic                r_ev_vld, n_ev_vld;
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [SIZE_W-1:0]   r_st, n_st;
    t_rsp                r_res, n_res;

    logic [IW-1:0]       rd_slot;
    logic [IW-1:0]       rd_start_addr;
    logic [IW-1:0]       rd_end_addr;
    t_slot               rd_q;
    logic                wr_en;
    t_slot               wr_data;

    logic [ADDR_W-1:0]   prev_end;
    logic [SIZE_W-1:0]   ev_st;
    logic                ev_last;
    logic                nxt_used;
    logic [SIZE_W-1:0]   nx;
    logic                room_ok;
    logic                alloc_hit;
    logic                free_hit;
    logic                hit;
    logic [17:0]         alloc_end;
    logic                alloc_ovf;
    logic                bad_size;

    assign rd_slot       = r_rd_idx[IW-1:0];
    assign rd_start_addr = (r_op == OP_ALLOC) ? rd_slot + IW'(1) : rd_slot;
    assign rd_end_addr   = rd_slot - IW'(1);

    stfa_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mem (
        .i_clk           (i_clk),
        .i_rd_start_addr (rd_start_addr),
        .i_rd_end_addr   (rd_end_addr),
        .o_rd            (rd_q),
        .i_wr_en         (wr_en),
        .i_wr_addr       (r_ev_idx),
        .i_wr            (wr_data)
    );

    // fit test for the slot read in the previous cycle
    always_comb begin
        prev_end  = r_used[r_ev_idx - IW'(1)] ? rd_q.end_addr : '0;
        ev_st     = (r_ev_idx == '0) ? '0 : {1'b0, prev_end} + SIZE_W'(1);
        ev_last   = (r_ev_idx == IW'(SLOT_COUNT - 1));
        nxt_used  = !ev_last && r_used[r_ev_idx + IW'(1)];
        nx        = {1'b0, rd_q.start_addr};
        room_ok   = (nx > ev_st) && ((nx - ev_st) >= r_size);
        alloc_hit = !r_used[r_ev_idx] && (!nxt_used || room_ok);
        free_hit  = r_used[r_ev_idx] &&
                    (({1'b0, rd_q.start_addr} + SIZE_W'(HEAP_OFFSET)) == {1'b0, r_faddr});
        hit       = r_ev_vld && ((r_op == OP_ALLOC) ? alloc_hit : free_hit);
    end

    assign alloc_end = 18'(r_st) + 18'(r_size) - 18'd1;
    assign alloc_ovf = (19'(alloc_end) + 19'(HEAP_OFFSET)) >= LIMIT_W;
    assign bad_size  = (i_req.request_size == '0) || (i_req.request_size > MAX_SIZE);

    assign wr_en              = (r_state == S_WRITE) && (r_op == OP_ALLOC) && !alloc_ovf;
    assign wr_data.start_addr = r_st[ADDR_W-1:0];
    assign wr_data.end_addr   = alloc_end[ADDR_W-1:0];

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        n_ev_idx = r_ev_idx;
        n_ev_vld = r_ev_vld;
        n_used   = r_used;
        n_st     = r_st;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
                n_ev_vld = 1'b0;
                if (i_req_valid) begin
                    if (t_op'(i_req.operation) == OP_ALLOC && bad_size) begin
                        n_res   = '{block_address: '0, status: ST_BAD_SIZE};
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_st    = ev_st;
                    n_state = S_WRITE;
                end else if (r_rd_idx == CW'(SLOT_COUNT)) begin
                    n_res.block_address = '0;
                    n_res.status = (r_op == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    n_state = S_RESULT;
                end else begin
                    n_ev_idx = rd_slot;
                    n_ev_vld = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                end
            end
            S_WRITE: begin
                if (r_op == OP_FREE) begin
                    n_used[r_ev_idx] = 1'b0;
                    n_res = '{block_address: '0, status: ST_OK};
                end else if (alloc_ovf) begin
                    n_res = '{block_address: '0, status: ST_OVERFLOW};
                end else begin
                    n_used[r_ev_idx] = 1'b1;
                    n_res.block_address = ADDR_W'(r_st + SIZE_W'(HEAP_OFFSET));
                    n_res.status = ST_OK;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= '0;
            r_ev_vld <= 1'b0;
            r_used   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_ev_vld <= n_ev_vld;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_op    <= t_op'(i_req.operation);
            r_size  <= i_req.request_size;
            r_faddr <= i_req.free_address;
        end
        r_ev_idx <= n_ev_idx;
        r_st     <= n_st;
        r_res    <= n_res;
    end

    `STFA_ASSERT_SAME(a_alloc_free_slot, i_clk, i_rst_n, (r_state == S_WRITE) && (r_op == OP_ALLOC), !r_used[r_ev_idx], "allocate targets a used slot")
    `STFA_ASSERT_SAME(a_free_used_slot, i_clk, i_rst_n, (r_state == S_WRITE) && (r_op == OP_FREE), r_used[r_ev_idx], "free targets an unused slot")
    `STFA_ASSERT_NEXT(a_alloc_marks_used, i_clk, i_rst_n, wr_en, r_used[$past(r_ev_idx)], "allocated slot not marked used")
    `STFA_ASSERT_SAME(a_ready_no_result, i_clk, i_rst_n, o_req_ready, !o_res_valid, "request taken while result pending")
    `STFA_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_rd_idx <= CW'(SLOT_COUNT), "scan index past last slot")

endmodule

/* hdl/slot_table_first_fit_allocator_top.sv */
// Top level of the slot table first-fit allocator: sequencer and output register.
// Depends on stfa_pkg, stfa_if and stfa_scan.
//
//  channel | dir | payload                                 | handshake
//  i_req   | in  | operation, request_size, free_address    | valid/ready
//  o_rsp   | out | block_address, status                   | valid/ready
//
// One item at a time. A bad size skips the scan and goes straight to the result. Otherwise the
// scan reads one slot per cycle from the slot memories; a hit on a slot goes through the
// write state to the result, a miss goes to the result after the last slot.
// Reset clears the used bits and the control registers; slot memories need no clearing pass.
// The output register holds a result under stall while the next item is taken.
module slot_table_first_fit_allocator_top import stfa_pkg::*; #(
    parameter int SLOT_COUNT   = 64,
    parameter int MEMORY_BYTES = 65536,
    parameter int HEAP_OFFSET  = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stfa_req_if.sink         i_req,
    stfa_rsp_if.source       o_rsp
);

    t_req req;
    t_rsp res;
    logic res_valid;
    logic res_ready;
    logic r_out_vld;
    t_rsp r_out;

    assign req.operation    = t_op'(i_req.operation);
    assign req.request_size = i_req.request_size;
    assign req.free_address = i_req.free_address;

    stfa_scan #(
        .SLOT_COUNT   (SLOT_COUNT),
        .MEMORY_BYTES (MEMORY_BYTES),
        .HEAP_OFFSET  (HEAP_OFFSET)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.block_address = r_out.block_address;
    assign o_rsp.status        = r_out.status;

endmodule
